// ===== rtl/assert_macros.svh =====
// Assertion macros used by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is high.
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(name, clk, rst, expr) \
   `ASSERT_CLK(name, clk, rst, !(expr))

`endif

// ===== rtl/fnmf_pkg.sv =====
// Package for the four-neighbor mean filter: widths, count codes, reciprocal.
package fnmf_pkg;

   localparam int FRAME_SIZE_DEF = 16;

   localparam int PIXEL_W = 8;
   localparam int MEAN_W  = 16;
   localparam int POS_W   = 4;
   localparam int RSP_W   = MEAN_W + 2 * POS_W;

   // four neighbors of 8 bits sum to at most 1020
   localparam int SUM_W = 10;
   localparam int CNT_W = 3;

   // neighbor counts
   localparam logic [CNT_W-1:0] CNT_CORNER = 3'd2;
   localparam logic [CNT_W-1:0] CNT_EDGE   = 3'd3;
   localparam logic [CNT_W-1:0] CNT_INNER  = 3'd4;

   // floor(x / 3) == (x * RECIP3) >> RECIP_SH for every x below 2**19
   localparam int RECIP_W  = 19;
   localparam int RECIP_SH = 20;
   localparam logic [RECIP_W-1:0] RECIP3 = 19'd349526;

endpackage

// ===== rtl/fnmf_mean.sv =====
// Rounded neighbor mean, 8 fraction bits, from a sum and a count of 2, 3 or 4.
module fnmf_mean (
   input  logic [fnmf_pkg::SUM_W-1:0]  sum,
   input  logic [fnmf_pkg::CNT_W-1:0]  cnt,
   output logic [fnmf_pkg::MEAN_W-1:0] mean
);
   import fnmf_pkg::*;

   localparam int X_W = SUM_W + 8;

   logic [X_W-1:0]         x3;
   logic [X_W+RECIP_W-1:0] prod3;

   // divide by 3: add half the divisor (1), then reciprocal multiply
   assign x3    = {sum, 8'd0} + X_W'(1);
   assign prod3 = x3 * RECIP3;

   always_comb begin
      case (cnt)
         // halves and quarters are exact after scaling by 256
         CNT_CORNER: mean = MEAN_W'({sum, 7'd0});
         CNT_INNER:  mean = MEAN_W'({sum, 6'd0});
         CNT_EDGE:   mean = MEAN_W'(prod3 >> RECIP_SH);
         default:    mean = '0;
      endcase
   end

endmodule

// ===== rtl/four_neighbor_mean_filter.sv =====
// Four-neighbor mean filter over a square frame, two line buffers in block RAM.
// First-row samples are written straight into a buffer without leaving idle;
// later samples pass from request to result load through accept, two RAM reads
// and output, bound by one read port per buffer, with no new request taken
// before the load. The frame's last sample adds a last-row flush. Reset
// (synchronous) clears state, position, bank and output valid; buffers keep their contents and need no clearing pass.
`include "assert_macros.svh"

module four_neighbor_mean_filter #(
   parameter int FRAME_SIZE = fnmf_pkg::FRAME_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [fnmf_pkg::PIXEL_W-1:0] req_tdata,   // [7:0] pixel
   // result channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [fnmf_pkg::RSP_W-1:0]  rsp_tdata,   // [15:0] mean, [19:16] out_row,
                                                    // [23:20] out_col
   output logic                        rsp_tlast    // last_of_burst
);
   import fnmf_pkg::*;

   localparam int CW = $clog2(FRAME_SIZE);
   localparam logic [CW-1:0] POS_LAST = CW'(FRAME_SIZE - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;  // take a request
   localparam logic [2:0] S_RD1  = 3'd1;  // above + left data back, fetch right
   localparam logic [2:0] S_RD2  = 3'd2;  // right data back
   localparam logic [2:0] S_OUT  = 3'd3;  // load result for the row above
   localparam logic [2:0] S_FRD  = 3'd4;  // flush: fetch above + left
   localparam logic [2:0] S_FR1  = 3'd5;  // flush: data back, fetch right
   localparam logic [2:0] S_FR2  = 3'd6;  // flush: right data back
   localparam logic [2:0] S_FOUT = 3'd7;  // flush: load result

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      row_ff, row_in;     // position of the next sample
   logic [CW-1:0]      col_ff, col_in;
   logic               bank_ff, bank_in;   // 0: older_mem is current row
   logic [CW-1:0]      fl_ff, fl_in;       // flush column
   logic [PIXEL_W-1:0] p_ff, p_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // line buffers, one write and one read port each, registered read data
   logic [PIXEL_W-1:0] older_mem [FRAME_SIZE];
   logic [PIXEL_W-1:0] newer_mem [FRAME_SIZE];
   logic [PIXEL_W-1:0] older_rd_ff, newer_rd_ff;
   logic [CW-1:0]      older_raddr, newer_raddr;
   logic               older_we, newer_we;

   // logical view: current row buffer vs previous row buffer
   logic               cur_we;
   logic [PIXEL_W-1:0] cur_wdata;
   logic [CW-1:0]      cur_raddr, prev_raddr;
   logic [PIXEL_W-1:0] cur_rd, prev_rd;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MEAN_W-1:0]  rsp_mean_ff;
   logic [POS_W-1:0]   rsp_row_ff, rsp_col_ff;
   logic               rsp_last_ff;
   logic [POS_W-1:0]   load_row, load_col;
   logic               load_last;

   logic               req_accept;
   logic               out_free;
   logic               load;
   logic               advance;
   logic               frame_end;
   logic [MEAN_W-1:0]  mean;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign frame_end  = (row_ff == POS_LAST) && (col_ff == POS_LAST);

   // bank select maps the logical buffers onto the two memories
   assign older_we    = cur_we && !bank_ff;
   assign newer_we    = cur_we && bank_ff;
   assign older_raddr = bank_ff ? prev_raddr : cur_raddr;
   assign newer_raddr = bank_ff ? cur_raddr : prev_raddr;
   assign cur_rd      = bank_ff ? newer_rd_ff : older_rd_ff;
   assign prev_rd     = bank_ff ? older_rd_ff : newer_rd_ff;

   always_ff @(posedge clock) begin
      if (older_we) begin
         older_mem[col_ff] <= cur_wdata;
      end
      older_rd_ff <= older_mem[older_raddr];
   end

   always_ff @(posedge clock) begin
      if (newer_we) begin
         newer_mem[col_ff] <= cur_wdata;
      end
      newer_rd_ff <= newer_mem[newer_raddr];
   end

   fnmf_mean u_mean (
      .sum  (sum_ff),
      .cnt  (cnt_ff),
      .mean (mean)
   );

   always_comb begin
      state_in   = state_ff;
      fl_in      = fl_ff;
      p_in       = p_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      cur_we     = 1'b0;
      cur_wdata  = p_ff;
      cur_raddr  = col_ff;
      prev_raddr = col_ff;
      load       = 1'b0;
      load_row   = POS_W'(row_ff - 1'b1);
      load_col   = POS_W'(col_ff);
      load_last  = !frame_end;
      advance    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // fetch the sample above (two rows back) and upper-left
            cur_raddr  = col_ff;
            prev_raddr = col_ff - 1'b1;
            if (req_accept) begin
               p_in = req_tdata;
               if (row_ff == '0) begin
                  // first row only fills the buffer
                  cur_we    = 1'b1;
                  cur_wdata = req_tdata;
                  advance   = 1'b1;
               end else begin
                  state_in = S_RD1;
               end
            end
         end
         S_RD1: begin
            sum_in = SUM_W'(p_ff)
                   + ((row_ff > CW'(1)) ? SUM_W'(cur_rd) : '0)
                   + ((col_ff != '0) ? SUM_W'(prev_rd) : '0);
            cnt_in = CNT_W'(1) + CNT_W'(row_ff > CW'(1)) + CNT_W'(col_ff != '0);
            prev_raddr = col_ff + 1'b1;
            // old entry is read, overwrite with the new sample
            cur_we   = 1'b1;
            state_in = S_RD2;
         end
         S_RD2: begin
            sum_in   = sum_ff + ((col_ff != POS_LAST) ? SUM_W'(prev_rd) : '0);
            cnt_in   = cnt_ff + CNT_W'(col_ff != POS_LAST);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               load = 1'b1;
               if (frame_end) begin
                  fl_in    = '0;
                  state_in = S_FRD;
               end else begin
                  advance  = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_FRD: begin
            // last row is now the current buffer, row above it the previous
            prev_raddr = fl_ff;
            cur_raddr  = fl_ff - 1'b1;
            state_in   = S_FR1;
         end
         S_FR1: begin
            sum_in    = SUM_W'(prev_rd) + ((fl_ff != '0) ? SUM_W'(cur_rd) : '0);
            cnt_in    = CNT_W'(1) + CNT_W'(fl_ff != '0);
            cur_raddr = fl_ff + 1'b1;
            state_in  = S_FR2;
         end
         S_FR2: begin
            sum_in   = sum_ff + ((fl_ff != POS_LAST) ? SUM_W'(cur_rd) : '0);
            cnt_in   = cnt_ff + CNT_W'(fl_ff != POS_LAST);
            state_in = S_FOUT;
         end
         S_FOUT: begin
            load_row  = POS_W'(row_ff);
            load_col  = POS_W'(fl_ff);
            load_last = (fl_ff == POS_LAST);
            if (out_free) begin
               load = 1'b1;
               if (fl_ff == POS_LAST) begin
                  advance  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  fl_in    = fl_ff + 1'b1;
                  state_in = S_FRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // raster position; bank flips at each row end
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      bank_in = bank_ff;
      if (advance) begin
         if (col_ff == POS_LAST) begin
            col_in  = '0;
            bank_in = !bank_ff;
            row_in  = (row_ff == POS_LAST) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fl_ff  <= fl_in;
      p_ff   <= p_in;
      sum_ff <= sum_in;
      cnt_ff <= cnt_in;
      if (load) begin
         rsp_mean_ff <= mean;
         rsp_row_ff  <= load_row;
         rsp_col_ff  <= load_col;
         rsp_last_ff <= load_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_col_ff, rsp_row_ff, rsp_mean_ff};
   assign rsp_tlast  = rsp_last_ff;

   // a request past the first row always starts the read sequence
   `ASSERT_CLK(a_rd_after_req, clock, reset, (req_accept && row_ff != '0) |=> (state_ff == S_RD1))
   // bank flips exactly at a row end
   `ASSERT_CLK(a_bank_flip, clock, reset, (advance && col_ff == POS_LAST) |=> (bank_ff != $past(bank_ff)))
   // flush runs only with the position parked on the frame's last sample
   `ASSERT_NEVER(a_flush_pos, clock, reset, (state_ff == S_FRD) && !frame_end)
   // a new result never overwrites one that is stalled
   `ASSERT_CLK(a_no_overwrite, clock, reset, (load && rsp_valid_ff) |-> rsp_tready)

endmodule
